@@ rtl/drlfe_pkg.sv @@
`timescale 1ns / 1ps

package drlfe_pkg;

   // Field widths fixed by the interface
   localparam int OPERATION_W     = 2;
   localparam int ADC_W           = 10;
   localparam int PATTERN_INDEX_W = 5;
   localparam int BYTE_W          = 8;
   localparam int BYTE_POS_W      = 5;
   localparam int SPI_WORD_W      = 64;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 10;

   // Operation codes
   localparam logic [OPERATION_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OPERATION_W-1:0] OP_ADC   = 2'd1;
   localparam logic [OPERATION_W-1:0] OP_TICK  = 2'd2;
   localparam logic [OPERATION_W-1:0] OP_NONE  = 2'd3;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_THRESHOLD  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN           = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE           = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BELOW_LOW_ON   = 3'd4;

   // Register reset values
   localparam logic [6:0] LOW_THRESHOLD_RESET  = 7'd50;
   localparam logic [6:0] HIGH_THRESHOLD_RESET = 7'd100;
   localparam logic [9:0] GAIN_RESET           = 10'd10;
   localparam logic [7:0] BASE_RESET           = 8'd1;
   localparam logic       BELOW_LOW_ON_RESET   = 1'b0;

   // Only the low byte of the brightness factor reaches the scaled output
   localparam logic [BYTE_W-1:0] FACTOR_RESET = 8'd1;

   typedef struct packed {
      logic [6:0] low_threshold_pct;
      logic [6:0] high_threshold_pct;
      logic [9:0] gain;
      logic [7:0] base_brightness;
      logic       below_low_on;
   } cfg_type;

   // Command handed from the front end to the frame engine
   typedef struct packed {
      logic [OPERATION_W-1:0]     op;
      logic [PATTERN_INDEX_W-1:0] index;
      logic [BYTE_W-1:0]          value;
      logic [BYTE_W-1:0]          factor;
   } cmd_type;

endpackage

@@ rtl/drlfe_front.sv @@
`timescale 1ns / 1ps

module drlfe_front
   import drlfe_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [OPERATION_W-1:0]     req_operation,
   input  logic [ADC_W-1:0]           req_adc_sample,
   input  logic [PATTERN_INDEX_W-1:0] req_pattern_index,
   input  logic [BYTE_W-1:0]          req_pattern_value,
   input  logic                       q_full,
   output logic                       q_push,
   output cmd_type                    q_cmd
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_MUL  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [OPERATION_W-1:0]     op_ff;
   logic [PATTERN_INDEX_W-1:0] idx_ff;
   logic [BYTE_W-1:0]          val_ff;
   logic [10:0]                term_ff, term_in;
   logic                       below_ff, below_in;
   logic [20:0]                prod_ff;

   logic [10:0] lo_val, hi_val, sample_ext;
   logic        accept;
   logic [BYTE_W-1:0] factor;

   assign accept   = req_push && !req_full;
   assign req_full = (state_ff != F_IDLE);

   // Thresholds are given in percent of a 1000-count scale
   assign lo_val = ({4'b0, cfg.low_threshold_pct} << 3) + ({4'b0, cfg.low_threshold_pct} << 1);
   assign hi_val = ({4'b0, cfg.high_threshold_pct} << 3)
                 + ({4'b0, cfg.high_threshold_pct} << 1);
   assign sample_ext = {1'b0, req_adc_sample};

   // Clamp at the high threshold wins over the off region
   always_comb begin
      term_in  = '0;
      below_in = 1'b0;
      priority if (sample_ext >= hi_val) begin
         term_in = (hi_val > lo_val) ? (hi_val - lo_val) : '0;
      end else if (sample_ext < lo_val) begin
         below_in = 1'b1;
      end else begin
         term_in = sample_ext - lo_val;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept && req_operation != OP_NONE) state_in = F_MUL;
         end
         F_MUL:  state_in = F_PUSH;
         F_PUSH: begin
            if (!q_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_operation;
         idx_ff   <= req_pattern_index;
         val_ff   <= req_pattern_value;
         term_ff  <= term_in;
         below_ff <= below_in;
      end
      if (state_ff == F_MUL) begin
         prod_ff <= {10'b0, term_ff} * {11'b0, cfg.gain};
      end
   end

   // Drop the fraction of the slope term; keep the low byte of the sum
   always_comb begin
      if (below_ff) begin
         factor = cfg.below_low_on ? cfg.base_brightness : '0;
      end else begin
         factor = prod_ff[17:10] + cfg.base_brightness;
      end
   end

   assign q_push       = (state_ff == F_PUSH) && !q_full;
   assign q_cmd.op     = op_ff;
   assign q_cmd.index  = idx_ff;
   assign q_cmd.value  = val_ff;
   assign q_cmd.factor = factor;

endmodule

@@ rtl/drlfe_queue.sv @@
`timescale 1ns / 1ps

module drlfe_queue
   import drlfe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type cmd_in,
   output logic    full,
   input  logic    pop,
   output cmd_type cmd_out,
   output logic    empty
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   assign full    = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign cmd_out = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= cmd_in;
   end

endmodule

@@ rtl/drlfe_back.sv @@
`timescale 1ns / 1ps

module drlfe_back
   import drlfe_pkg::*;
#(
   parameter int FRAME_BYTES = 24
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               q_cmd,
   input  logic                  q_empty,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [SPI_WORD_W-1:0] rsp_spi_word,
   output logic [BYTE_POS_W-1:0] rsp_byte_position,
   output logic [BYTE_W-1:0]     rsp_scaled_byte,
   output logic                  rsp_frame_last
);

   localparam int POS_W = $clog2(FRAME_BYTES);
   localparam int IDX_W = (POS_W > PATTERN_INDEX_W) ? POS_W : PATTERN_INDEX_W;
   localparam logic [POS_W:0]   WRAP     = (POS_W+1)'(3 * (FRAME_BYTES / 3));
   localparam logic [POS_W:0]   FRAME_N  = (POS_W+1)'(FRAME_BYTES);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
   localparam logic [POS_W:0]   LED_STEP = (POS_W+1)'(3);
   localparam int PATTERN_TEST_BYTES = 9;
   localparam logic [BYTE_W-1:0] SPI_ONE  = 8'b0111_1100;
   localparam logic [BYTE_W-1:0] SPI_ZERO = 8'b0111_0000;

   localparam logic B_IDLE = 1'b0;
   localparam logic B_EMIT = 1'b1;

   function automatic logic [SPI_WORD_W-1:0] spi_encode(input logic [BYTE_W-1:0] b);
      logic [SPI_WORD_W-1:0] w;
      w = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         w[i*8 +: 8] = b[i] ? SPI_ONE : SPI_ZERO;
      end
      return w;
   endfunction

   // Power-up test pattern: one byte lit in each of the first three LEDs; later bytes read 1
   function automatic logic [BYTE_W-1:0] pattern_reset_value(input logic [POS_W-1:0] idx);
      logic zero;
      zero = (int'(idx) < PATTERN_TEST_BYTES) && (idx[1:0] != 2'b00);
      return zero ? 8'd0 : 8'd1;
   endfunction

   logic                   state_ff;
   logic [POS_W-1:0]       rot_ff;
   logic [BYTE_W-1:0]      factor_ff;
   logic [POS_W-1:0]       pos_ff, src_ff;
   logic [FRAME_BYTES-1:0] valid_ff;
   logic [BYTE_W-1:0]      mem [FRAME_BYTES];

   logic                   s1_vld_ff;
   logic [POS_W-1:0]       s1_pos_ff, s1_src_ff;
   logic                   s1_hit_ff;
   logic [BYTE_W-1:0]      s1_data_ff;

   logic                   out_vld_ff;
   logic [SPI_WORD_W-1:0]  out_spi_ff;
   logic [BYTE_POS_W-1:0]  out_pos_ff;
   logic [BYTE_W-1:0]      out_byte_ff;
   logic                   out_last_ff;

   logic                   adv, issue, wr_hit;
   logic [POS_W:0]         rot_step, start_sum, start_wrap;
   logic [POS_W-1:0]       rot_tick, rot_use, start_src, waddr;
   logic [IDX_W-1:0]       idx_ext;
   logic [BYTE_W-1:0]      s1_byte, scaled_in;
   logic [2*BYTE_W-1:0]    prod;

   // Whole pipeline moves only when the output register can take a result
   assign adv   = !out_vld_ff || rsp_pop;
   assign q_pop = adv && (state_ff == B_IDLE) && !q_empty;
   assign issue = adv && (state_ff == B_EMIT);

   // Rotation is kept in bytes, three per LED
   assign rot_step = {1'b0, rot_ff} + LED_STEP;
   assign rot_tick = (rot_step >= WRAP) ? '0 : rot_step[POS_W-1:0];
   assign rot_use  = (q_cmd.op == OP_TICK) ? rot_tick : rot_ff;

   assign start_sum  = {1'b0, rot_use} + {1'b0, LAST_POS};
   assign start_wrap = start_sum - FRAME_N;
   assign start_src  = (start_sum >= FRAME_N) ? start_wrap[POS_W-1:0] : start_sum[POS_W-1:0];

   assign idx_ext = IDX_W'(q_cmd.index);
   assign waddr   = idx_ext[POS_W-1:0];
   assign wr_hit  = q_pop && (q_cmd.op == OP_WRITE)
                 && ({1'b0, idx_ext} < (IDX_W+1)'(FRAME_BYTES));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         rot_ff     <= '0;
         factor_ff  <= FACTOR_RESET;
         valid_ff   <= '0;
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (wr_hit) valid_ff[waddr] <= 1'b1;
         if (adv) begin
            s1_vld_ff  <= issue;
            out_vld_ff <= s1_vld_ff;
            unique case (state_ff)
               B_IDLE: begin
                  if (!q_empty) begin
                     unique case (q_cmd.op)
                        OP_ADC: begin
                           factor_ff <= q_cmd.factor;
                           state_ff  <= B_EMIT;
                        end
                        OP_TICK: begin
                           rot_ff   <= rot_tick;
                           state_ff <= B_EMIT;
                        end
                        default: ;
                     endcase
                  end
               end
               B_EMIT: begin
                  if (pos_ff == '0) state_ff <= B_IDLE;
               end
               default: state_ff <= B_IDLE;
            endcase
         end
      end
   end

   // Walk the frame from the last byte down, source index wraps with it
   always_ff @(posedge clock) begin
      if (q_pop) begin
         pos_ff <= LAST_POS;
         src_ff <= start_src;
      end else if (issue) begin
         pos_ff <= pos_ff - 1'b1;
         src_ff <= (src_ff == '0) ? LAST_POS : src_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_hit) mem[waddr] <= q_cmd.value;
      if (issue) s1_data_ff <= mem[src_ff];
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_pos_ff <= pos_ff;
         s1_src_ff <= src_ff;
         s1_hit_ff <= valid_ff[src_ff];
      end
   end

   assign s1_byte   = s1_hit_ff ? s1_data_ff : pattern_reset_value(s1_src_ff);
   assign prod      = {8'b0, s1_byte} * {8'b0, factor_ff};
   assign scaled_in = prod[BYTE_W-1:0];

   always_ff @(posedge clock) begin
      if (adv && s1_vld_ff) begin
         out_spi_ff  <= spi_encode(scaled_in);
         out_pos_ff  <= BYTE_POS_W'(s1_pos_ff);
         out_byte_ff <= scaled_in;
         out_last_ff <= (s1_pos_ff == '0);
      end
   end

   assign rsp_empty         = !out_vld_ff;
   assign rsp_spi_word      = out_spi_ff;
   assign rsp_byte_position = out_pos_ff;
   assign rsp_scaled_byte   = out_byte_ff;
   assign rsp_frame_last    = out_last_ff;

endmodule

@@ rtl/dimmed_rotating_led_frame_encoder.sv @@
`timescale 1ns / 1ps

// LED frame encoder: a brightness sample (operation 1) or a rotation tick
// (operation 2) each produce one frame of FRAME_BYTES results, last byte first,
// every result holding one scaled colour byte as eight SPI bytes; a pattern
// write (operation 0) and the unused code produce nothing. The front end takes
// one item at a time and holds req_full until it is done (threshold compare,
// gain multiply, queue push, which waits while the queue is full; the unused
// code is dropped on acceptance) and hands it through a 4-entry command queue
// to the frame engine. The engine takes a command, then sends one result per
// cycle while rsp_pop is held, taking no new command until the frame is sent.
// A pattern write only updates the engine's pattern memory. Configuration is
// applied at once; change it only while no transaction is in flight.
module dimmed_rotating_led_frame_encoder
   import drlfe_pkg::*;
#(
   parameter int FRAME_BYTES = 24
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [OPERATION_W-1:0]     req_operation,
   input  logic [ADC_W-1:0]           req_adc_sample,
   input  logic [PATTERN_INDEX_W-1:0] req_pattern_index,
   input  logic [BYTE_W-1:0]          req_pattern_value,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [SPI_WORD_W-1:0]      rsp_spi_word,
   output logic [BYTE_POS_W-1:0]      rsp_byte_position,
   output logic [BYTE_W-1:0]          rsp_scaled_byte,
   output logic                       rsp_frame_last,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   cfg_type cfg_ff;
   cmd_type push_cmd, head_cmd;
   logic    q_push, q_full, q_pop, q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_threshold_pct  <= LOW_THRESHOLD_RESET;
         cfg_ff.high_threshold_pct <= HIGH_THRESHOLD_RESET;
         cfg_ff.gain               <= GAIN_RESET;
         cfg_ff.base_brightness    <= BASE_RESET;
         cfg_ff.below_low_on       <= BELOW_LOW_ON_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LOW_THRESHOLD:  cfg_ff.low_threshold_pct  <= csr_wdata[6:0];
            CSR_HIGH_THRESHOLD: cfg_ff.high_threshold_pct <= csr_wdata[6:0];
            CSR_GAIN:           cfg_ff.gain               <= csr_wdata[9:0];
            CSR_BASE:           cfg_ff.base_brightness    <= csr_wdata[7:0];
            CSR_BELOW_LOW_ON:   cfg_ff.below_low_on       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   drlfe_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_operation     (req_operation),
      .req_adc_sample    (req_adc_sample),
      .req_pattern_index (req_pattern_index),
      .req_pattern_value (req_pattern_value),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_cmd             (push_cmd)
   );

   drlfe_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .cmd_in  (push_cmd),
      .full    (q_full),
      .pop     (q_pop),
      .cmd_out (head_cmd),
      .empty   (q_empty)
   );

   drlfe_back #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_cmd             (head_cmd),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_spi_word      (rsp_spi_word),
      .rsp_byte_position (rsp_byte_position),
      .rsp_scaled_byte   (rsp_scaled_byte),
      .rsp_frame_last    (rsp_frame_last)
   );

endmodule

@@ rtl/drlfe_checker.sv @@
`timescale 1ns / 1ps

module drlfe_checker
   import drlfe_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input logic [SPI_WORD_W-1:0] rsp_spi_word,
   input logic [BYTE_POS_W-1:0] rsp_byte_position,
   input logic [BYTE_W-1:0]     rsp_scaled_byte,
   input logic                  rsp_frame_last
);

   localparam logic [BYTE_W-1:0] SPI_ONE  = 8'b0111_1100;
   localparam logic [BYTE_W-1:0] SPI_ZERO = 8'b0111_0000;

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_spi_word)
                                    && $stable(rsp_byte_position)))
      else $error("waiting result changed or vanished");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_frame_last == (rsp_byte_position == '0)))
      else $error("frame_last does not match byte position zero");

   a_encode: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_spi_word[63:56] == (rsp_scaled_byte[7] ? SPI_ONE : SPI_ZERO))
                   && (rsp_spi_word[7:0] == (rsp_scaled_byte[0] ? SPI_ONE : SPI_ZERO))))
      else $error("SPI word does not encode scaled byte");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_frame_last) |=>
         (rsp_empty || rsp_byte_position == ($past(rsp_byte_position) - 5'd1)))
      else $error("frame byte position skipped");

endmodule

bind dimmed_rotating_led_frame_encoder drlfe_checker u_drlfe_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_spi_word      (rsp_spi_word),
   .rsp_byte_position (rsp_byte_position),
   .rsp_scaled_byte   (rsp_scaled_byte),
   .rsp_frame_last    (rsp_frame_last)
);
